// ===== rtl/bsc_pkg.sv =====
// Shared constants, types and codes for the banker's safety checker.
// Used by bsc_lane, bsc_merge and bankers_safety_checker_unit; no dependencies.
`default_nettype none

package bsc_pkg;

  localparam int NUM_PROCESSES = 4;
  localparam int NUM_RESOURCES = 3;
  localparam int COUNT_WIDTH   = 8;

  localparam int PROC_W = $clog2(NUM_PROCESSES);
  // work = available plus every allocation: never overflows at this width
  localparam int WORK_W = COUNT_WIDTH + $clog2(NUM_PROCESSES + 1);

  typedef logic [COUNT_WIDTH-1:0]              count_t;
  typedef logic [WORK_W-1:0]                   work_t;
  typedef logic [PROC_W-1:0]                   proc_t;
  typedef count_t [NUM_RESOURCES-1:0]          count_vec_t;
  typedef work_t  [NUM_RESOURCES-1:0]          work_vec_t;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_REQ   = 2'd2,
    ACT_CHECK = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_LOADED      = 3'd0,
    ST_SAFE        = 3'd1,
    ST_UNSAFE      = 3'd2,
    ST_EXCEEDS     = 3'd3,
    ST_MUST_WAIT   = 3'd4,
    ST_LOAD_REJECT = 3'd5
  } status_e;

  // What one lane reports for its process in the current scan step
  typedef struct packed {
    logic       fits;
    count_vec_t alloc;
  } lane_out_t;

  // Result of combining the lanes
  typedef struct packed {
    logic      found;
    proc_t     pick;
    work_vec_t work;
  } merge_t;

endpackage

`default_nettype wire

// ===== rtl/bsc_lane.sv =====
// One process lane: checks whether the process's remaining need fits the work vector.
// Applies a pending request to the row first. Depends on bsc_pkg.
`default_nettype none

module bsc_lane
  import bsc_pkg::*;
(
  input  var count_vec_t alloc_i,
  input  var count_vec_t need_i,
  input  var count_vec_t req_i,
  input  var logic       own_i,
  input  var logic       done_i,
  input  var work_vec_t  work_i,
  output var lane_out_t  lane_o
);

  count_vec_t eff_need;
  logic       all_fit;

  always_comb begin
    all_fit = 1'b1;
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      eff_need[r]      = own_i ? count_t'(need_i[r] - req_i[r]) : need_i[r];
      lane_o.alloc[r]  = own_i ? count_t'(alloc_i[r] + req_i[r]) : alloc_i[r];
      if (work_t'(eff_need[r]) > work_i[r]) begin
        all_fit = 1'b0;
      end
    end
    lane_o.fits = all_fit & ~done_i;
  end

endmodule

`default_nettype wire

// ===== rtl/bsc_merge.sv =====
// Merge stage: picks the lowest-index fitting lane and returns its allocation to work.
// Depends on bsc_pkg.
`default_nettype none

module bsc_merge
  import bsc_pkg::*;
(
  input  var lane_out_t [NUM_PROCESSES-1:0] lanes_i,
  input  var work_vec_t                     work_i,
  output var merge_t                        merge_o
);

  count_vec_t sel_alloc;

  always_comb begin
    merge_o.found = 1'b0;
    merge_o.pick  = '0;
    sel_alloc     = '0;
    for (int p = NUM_PROCESSES - 1; p >= 0; p--) begin
      if (lanes_i[p].fits) begin
        merge_o.found = 1'b1;
        merge_o.pick  = proc_t'(p);
        sel_alloc     = lanes_i[p].alloc;
      end
    end
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      merge_o.work[r] = work_t'(work_i[r] + work_t'(sel_alloc[r]));
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bankers_safety_checker_unit.sv =====
// Top level of the banker's deadlock-avoidance checker: state tables, control and
// output register. Depends on bsc_pkg, bsc_lane and bsc_merge.
//
// Usage:
//   Requests enter on in_valid_i / in_stall_o with action_i, process_i, unit_*_i and
//   max_*_i; one response per request leaves on out_valid_o / out_stall_i with
//   status_o and order_0_o..order_3_o (orders are zero unless status is safe).
//   Load, set-available and refused requests answer without a scan: the response is
//   visible the cycle after acceptance.
//   A safety check, or a request that passes the need and availability tests, runs
//   the safety scan: one lane per process tests need against work in parallel and
//   the merge stage grants the lowest fitting process, one grant per cycle. The
//   scan ends at the first step with no fitting process, or once every process
//   has been granted; the response is registered when the scan ends. Only one
//   request is in flight at a time: no new request is taken during a scan.
//   A granted request is committed only when the scan ends safe; otherwise the
//   tables are left as they were.
//   Reset clears allocation, need and available tables and drops any response.
//   While the receiver stalls, the response holds; a new request is still taken
//   when the output is draining in that cycle, otherwise in_stall_o stays high.
`default_nettype none

module bankers_safety_checker_unit
  import bsc_pkg::*;
(
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       in_valid_i,
  output var logic       in_stall_o,
  input  var logic [1:0] action_i,
  input  var logic [1:0] process_i,
  input  var logic [7:0] unit_0_i,
  input  var logic [7:0] unit_1_i,
  input  var logic [7:0] unit_2_i,
  input  var logic [7:0] max_0_i,
  input  var logic [7:0] max_1_i,
  input  var logic [7:0] max_2_i,
  output var logic       out_valid_o,
  input  var logic       out_stall_i,
  output var logic [2:0] status_o,
  output var logic [1:0] order_0_o,
  output var logic [1:0] order_1_o,
  output var logic [1:0] order_2_o,
  output var logic [1:0] order_3_o
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  localparam int LAST_STEP = NUM_PROCESSES - 1;

  state_e state_q;

  // Banker's tables
  count_vec_t [NUM_PROCESSES-1:0] alloc_q;
  count_vec_t [NUM_PROCESSES-1:0] need_q;
  count_vec_t                     avail_q;

  // Scan context
  logic                       grant_q;
  proc_t                      proc_q;
  count_vec_t                 req_q;
  work_vec_t                  work_q;
  logic [NUM_PROCESSES-1:0]   done_q;
  proc_t [NUM_PROCESSES-1:0]  seq_q;
  proc_t                      step_q;

  // Output register
  logic       out_valid_q;
  status_e    status_q;
  logic [1:0] order_q [4];

  count_vec_t unit_vec;
  count_vec_t max_vec;
  proc_t      proc_in;
  action_e    action_in;
  logic       proc_ok;
  logic       load_ok;
  logic       over_need;
  logic       must_wait;
  logic       respond_now;
  logic       accept;
  proc_t [NUM_PROCESSES-1:0] seq_next;

  lane_out_t [NUM_PROCESSES-1:0] lanes;
  merge_t                        merge;

  // Unpack the request and run the immediate checks
  always_comb begin
    unit_vec  = '0;
    max_vec   = '0;
    unit_vec[0] = count_t'(unit_0_i);
    unit_vec[1] = count_t'(unit_1_i);
    unit_vec[2] = count_t'(unit_2_i);
    max_vec[0]  = count_t'(max_0_i);
    max_vec[1]  = count_t'(max_1_i);
    max_vec[2]  = count_t'(max_2_i);
    proc_in   = proc_t'(process_i);
    action_in = action_e'(action_i);
    proc_ok   = (int'(process_i) < NUM_PROCESSES);
    load_ok   = proc_ok;
    over_need = ~proc_ok;
    must_wait = 1'b0;
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      if (unit_vec[r] > max_vec[r]) begin
        load_ok = 1'b0;
      end
      if (proc_ok && (unit_vec[r] > need_q[proc_in][r])) begin
        over_need = 1'b1;
      end
      if (unit_vec[r] > avail_q[r]) begin
        must_wait = 1'b1;
      end
    end
    // load, set and refused requests answer without a scan
    respond_now = (action_in == ACT_LOAD) || (action_in == ACT_SET) ||
                  ((action_in == ACT_REQ) && (over_need || must_wait));
  end

  // Take a new request only when idle and the output slot frees up
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // One lane per process
  for (genvar p = 0; p < NUM_PROCESSES; p++) begin : g_lane
    bsc_lane u_lane (
      .alloc_i (alloc_q[p]),
      .need_i  (need_q[p]),
      .req_i   (req_q),
      .own_i   (grant_q && (proc_q == proc_t'(p))),
      .done_i  (done_q[p]),
      .work_i  (work_q),
      .lane_o  (lanes[p])
    );
  end

  bsc_merge u_merge (
    .lanes_i (lanes),
    .work_i  (work_q),
    .merge_o (merge)
  );

  always_comb begin
    seq_next         = seq_q;
    seq_next[step_q] = merge.pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alloc_q     <= '0;
      need_q      <= '0;
      avail_q     <= '0;
      grant_q     <= 1'b0;
      done_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the response once taken; a request taken in the same cycle sets its own
      if (out_valid_q && !out_stall_i && !accept) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_valid_q <= respond_now;
            for (int k = 0; k < 4; k++) begin
              order_q[k] <= '0;
            end
            done_q  <= '0;
            step_q  <= '0;
            proc_q  <= proc_in;
            req_q   <= unit_vec;
            grant_q <= 1'b0;
            for (int r = 0; r < NUM_RESOURCES; r++) begin
              work_q[r] <= work_t'(avail_q[r]);
            end
            case (action_in)
              ACT_LOAD: begin
                if (load_ok) begin
                  status_q        <= ST_LOADED;
                  alloc_q[proc_in] <= unit_vec;
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                    need_q[proc_in][r] <= count_t'(max_vec[r] - unit_vec[r]);
                  end
                end else begin
                  status_q <= ST_LOAD_REJECT;
                end
              end
              ACT_SET: begin
                status_q    <= ST_LOADED;
                avail_q     <= unit_vec;
              end
              ACT_REQ: begin
                if (over_need) begin
                  status_q    <= ST_EXCEEDS;
                end else if (must_wait) begin
                  status_q    <= ST_MUST_WAIT;
                end else begin
                  // scan the tentative state: work starts from available minus request
                  grant_q <= 1'b1;
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                    work_q[r] <= work_t'(count_t'(avail_q[r] - unit_vec[r]));
                  end
                  state_q <= S_SCAN;
                end
              end
              ACT_CHECK: begin
                state_q <= S_SCAN;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (!merge.found) begin
            // no candidate: unsafe, leave the tables untouched
            out_valid_q <= 1'b1;
            status_q    <= ST_UNSAFE;
            state_q     <= S_IDLE;
          end else begin
            done_q[merge.pick] <= 1'b1;
            seq_q              <= seq_next;
            work_q             <= merge.work;
            step_q             <= step_q + proc_t'(1);
            if (step_q == proc_t'(LAST_STEP)) begin
              out_valid_q <= 1'b1;
              status_q    <= ST_SAFE;
              for (int k = 0; k < 4 && k < NUM_PROCESSES; k++) begin
                order_q[k] <= 2'(seq_next[k]);
              end
              // commit the granted request
              if (grant_q) begin
                for (int r = 0; r < NUM_RESOURCES; r++) begin
                  avail_q[r]         <= count_t'(avail_q[r] - req_q[r]);
                  alloc_q[proc_q][r] <= count_t'(alloc_q[proc_q][r] + req_q[r]);
                  need_q[proc_q][r]  <= count_t'(need_q[proc_q][r] - req_q[r]);
                end
              end
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign order_0_o   = order_q[0];
  assign order_1_o   = order_q[1];
  assign order_2_o   = order_q[2];
  assign order_3_o   = order_q[3];

endmodule

`default_nettype wire
